@@ src/scan_candidate_table_rssi_sorted_defines.svh @@
// Assertion macros for the scan candidate table.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SCAN_CANDIDATE_TABLE_RSSI_SORTED_DEFINES_SVH
`define SCAN_CANDIDATE_TABLE_RSSI_SORTED_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sct check failed");
// next-cycle implication, disabled in reset
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sct check failed");
`else
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/sct_pkg.sv @@
// Shared types and constants for the scan candidate table.
// No dependencies.
`default_nettype none
package sct_pkg;
	localparam int SCT_TABLE_DEPTH = 16;
	localparam int SCT_ADDR_W      = 48;
	localparam int SCT_RSSI_W      = 8;
	localparam int SCT_COUNT_OUT_W = 5;

	// op codes carried in s_tuser
	localparam logic SCT_OP_CLEAR = 1'b0;
	localparam logic SCT_OP_OFFER = 1'b1;

	typedef struct packed {
		logic                         kind;
		logic [SCT_ADDR_W-1:0]        addr;
		logic signed [SCT_RSSI_W-1:0] rssi;
	} entry_t;
endpackage
`default_nettype wire

@@ src/scan_candidate_table_rssi_sorted.sv @@
// Scan candidate table: sorted peer list with duplicate rejection.
// Depends on sct_pkg and scan_candidate_table_rssi_sorted_defines.svh.
//
//   channel  dir  tdata (low bit up)                              tuser
//   s_*      in   peer_kind[0] address[48:1] rssi[56:49] 0[63:57] op
//   m_*      out  entry_count[4:0] best_valid[5] best_kind[6]
//                 best_address[54:7] best_rssi[62:55] 0[63]       accepted,dup,full
//
// One word at a time. A clear goes from idle straight to the result state. An
// offer walks the table once through the single read port of the entry store,
// then shifts each weaker entry down one slot (read, write on the same port
// pair), then writes the new entry.
// s_tready is high only while idle; the result is held on m_* until taken.
// arst_n clears count and control; the entry store is not reset.
`default_nettype none
`include "scan_candidate_table_rssi_sorted_defines.svh"
module scan_candidate_table_rssi_sorted
	import sct_pkg::*;
#(
	parameter int TABLE_DEPTH = SCT_TABLE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // peer_kind, peer_address, peer_rssi
	input  wire logic        s_tuser,   // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // entry_count, best_valid, best_kind,
	                                    // best_address, best_rssi
	output logic [2:0]       m_tuser    // accepted, was_duplicate, was_full
);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN     = 3'd1;
	localparam logic [2:0] ST_WAIT     = 3'd2;
	localparam logic [2:0] ST_DECIDE   = 3'd3;
	localparam logic [2:0] ST_SHIFT_RD = 3'd4;
	localparam logic [2:0] ST_SHIFT_WR = 3'd5;
	localparam logic [2:0] ST_INS      = 3'd6;
	localparam logic [2:0] ST_OUT      = 3'd7;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;     // insert slot, first entry weaker than new
	logic             pos_found_q;
	logic [IDX_W-1:0] ridx_q;    // scan read pointer
	logic [IDX_W-1:0] widx_q;    // shift write pointer
	logic             acc_q;
	logic             dup_q;
	logic             full_q;
	entry_t           new_q;     // offered peer
	entry_t           best_q;    // shadow of slot 0

	// entry store: one write port, one registered read port
	entry_t           entry_store [TABLE_DEPTH];
	entry_t           rdata_q;
	logic [IDX_W-1:0] raddr;
	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;

	// scan compare stage
	logic             rvld_s1;
	logic [IDX_W-1:0] cidx_s1;

	logic             in_fire;
	logic             best_valid;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign in_fire  = s_tvalid && s_tready;

	assign raddr = (state_q == ST_SHIFT_RD) ? (widx_q - 1'b1) : ridx_q;
	assign we    = (state_q == ST_SHIFT_WR) || (state_q == ST_INS);
	assign waddr = (state_q == ST_SHIFT_WR) ? widx_q : pos_q[IDX_W-1:0];
	assign wdata = (state_q == ST_SHIFT_WR) ? rdata_q : new_q;

	always_ff @(posedge clk) begin
		if (we) begin
			entry_store[waddr] <= wdata;
		end
		rdata_q <= entry_store[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		cidx_s1 <= ridx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			pos_found_q <= 1'b0;
			ridx_q      <= '0;
			widx_q      <= '0;
			acc_q       <= 1'b0;
			dup_q       <= 1'b0;
			full_q      <= 1'b0;
		end else begin
			// compare stage runs behind the scan reads
			if (rvld_s1) begin
				if (rdata_q.kind == new_q.kind && rdata_q.addr == new_q.addr) begin
					dup_q <= 1'b1;
				end
				if (!pos_found_q && rdata_q.rssi < new_q.rssi) begin
					pos_q       <= CNT_W'(cidx_s1);
					pos_found_q <= 1'b1;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						acc_q       <= 1'b0;
						dup_q       <= 1'b0;
						full_q      <= 1'b0;
						pos_q       <= count_q;
						pos_found_q <= 1'b0;
						ridx_q      <= '0;
						if (s_tuser == SCT_OP_CLEAR) begin
							count_q <= '0;
							state_q <= ST_OUT;
						end else if (count_q == '0) begin
							state_q <= ST_DECIDE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					ridx_q <= ridx_q + 1'b1;
					if (CNT_W'(ridx_q) == count_q - 1'b1) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					widx_q <= count_q[IDX_W-1:0];
					if (dup_q) begin
						state_q <= ST_OUT;
					end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
						full_q  <= 1'b1;
						state_q <= ST_OUT;
					end else if (count_q == pos_q) begin
						state_q <= ST_INS;
					end else begin
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					widx_q <= widx_q - 1'b1;
					if ((widx_q - 1'b1) == pos_q[IDX_W-1:0]) begin
						state_q <= ST_INS;
					end else begin
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_INS: begin
					count_q <= count_q + 1'b1;
					acc_q   <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: offered peer and slot 0 shadow
	always_ff @(posedge clk) begin
		if (in_fire) begin
			new_q.kind <= s_tdata[0];
			new_q.addr <= s_tdata[48:1];
			new_q.rssi <= s_tdata[56:49];
		end
		if (state_q == ST_INS && pos_q == '0) begin
			best_q <= new_q;
		end
	end

	assign best_valid = (count_q != '0);

	always_comb begin
		m_tdata        = '0;
		m_tdata[4:0]   = SCT_COUNT_OUT_W'(count_q);
		m_tdata[5]     = best_valid;
		m_tdata[6]     = best_valid ? best_q.kind : 1'b0;
		m_tdata[54:7]  = best_valid ? best_q.addr : '0;
		m_tdata[62:55] = best_valid ? best_q.rssi : '0;
		m_tuser        = {full_q, dup_q, acc_q};
	end

	`SCT_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
	`SCT_ASSERT_IMP(a_one_outcome, clk, arst_n, m_tvalid, $countones(m_tuser) <= 1)
	`SCT_ASSERT_IMP(a_no_overlap, clk, arst_n, 1'b1, !(s_tready && m_tvalid))
	`SCT_ASSERT_NXT(a_ins_count, clk, arst_n, state_q == ST_INS,
		count_q == $past(count_q) + 1'b1)
	`SCT_ASSERT_IMP(a_full_refuse, clk, arst_n, m_tvalid && m_tuser[2],
		count_q == CNT_W'(TABLE_DEPTH))
endmodule
`default_nettype wire
